// File: rtl/pbh_pkg.sv
// Package for the programmable bit-operation hash: sizes, codes, the program word
// and pipeline payload types, and the function that executes one operation.
// Used by every module under rtl; depends on nothing.
package pbh_pkg;

    localparam int KEY_WIDTH = 10;
    localparam int NUM_REGS  = 4;
    localparam int MAX_OPS   = 16;

    localparam int ACTION_W = 1;
    localparam int SLOT_W   = 4;
    localparam int KIND_W   = 3;
    localparam int REG_SEL_W = 2;
    localparam int FIELD_W  = 10;
    localparam int SHAMT_W  = 5;
    localparam int LEN_W    = 5;
    localparam int HASH_W   = 10;

    localparam int REG_SPACE = 2 ** REG_SEL_W;
    localparam int STAGE_W   = (MAX_OPS > 1) ? $clog2(MAX_OPS) : 1;
    localparam int CMP_W     = SLOT_W + STAGE_W + LEN_W;

    localparam int PIPE_LATENCY = MAX_OPS + 1;

    // Rotates are done by selecting a window out of a repeated copy of the operand.
    localparam int SHAMT_SPAN      = 2 ** (SHAMT_W - 1);
    localparam int ROT_LEFT_COPIES = (SHAMT_SPAN + KEY_WIDTH - 1) / KEY_WIDTH;
    localparam int ROT_COPIES      = ROT_LEFT_COPIES + 1;
    localparam int ROT_BITS        = ROT_COPIES * KEY_WIDTH;
    localparam int ROT_SH_W        = $clog2(ROT_BITS);
    localparam int ROT_OFF         = ROT_LEFT_COPIES * KEY_WIDTH;

    localparam logic [ACTION_W-1:0] ACT_LOAD = 1'b0;
    localparam logic [ACTION_W-1:0] ACT_HASH = 1'b1;

    typedef enum logic [KIND_W-1:0] {
        OP_MASK   = 3'd0,
        OP_OR     = 3'd1,
        OP_XOR    = 3'd2,
        OP_SHIFT  = 3'd3,
        OP_ROTATE = 3'd4
    } op_kind_t;

    typedef logic [KEY_WIDTH-1:0] key_t;
    typedef logic [REG_SPACE-1:0][KEY_WIDTH-1:0] reg_file_t;

    typedef struct packed {
        logic [KIND_W-1:0]    kind;
        logic [REG_SEL_W-1:0] src1;
        logic [REG_SEL_W-1:0] src2;
        logic [REG_SEL_W-1:0] dst;
        key_t                 mask;
        logic [SHAMT_W-1:0]   shamt;
    } op_t;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [SLOT_W-1:0]   slot;
        op_t                 op;
        reg_file_t           regs;
    } pipe_t;

    function automatic reg_file_t exec_op(input reg_file_t r, input op_t op);
        reg_file_t             r_out;
        key_t                  a;
        key_t                  b;
        key_t                  res;
        logic                  wr;
        logic [SHAMT_W-1:0]    mag;
        logic [ROT_BITS-1:0]   rep;
        logic [ROT_SH_W-1:0]   off;
        r_out = r;
        a     = (32'(op.src1) < NUM_REGS) ? r[op.src1] : '0;
        b     = (32'(op.src2) < NUM_REGS) ? r[op.src2] : '0;
        mag   = ~op.shamt + 1'b1;
        rep   = {ROT_COPIES{a}};
        off   = ROT_SH_W'(ROT_OFF) - ROT_SH_W'(mag);
        res   = '0;
        wr    = 1'b1;
        case (op.kind)
            OP_MASK:  res = a & op.mask;
            OP_OR:    res = a | b;
            OP_XOR:   res = a ^ b;
            OP_SHIFT:
            begin
                if (op.shamt[SHAMT_W-1])
                    res = a << mag;
                else
                    res = a >> op.shamt;
            end
            OP_ROTATE:
            begin
                if (op.shamt[SHAMT_W-1])
                    res = KEY_WIDTH'(rep >> off);
                else
                    res = KEY_WIDTH'(rep >> op.shamt);
            end
            default:  wr = 1'b0;
        endcase
        if (wr && (32'(op.dst) < NUM_REGS))
            r_out[op.dst] = res;
        return r_out;
    endfunction

endpackage

// File: rtl/pbh_stage.sv
// One program slot of the hash pipeline: the slot's operation register and one
// pipeline register that carries each transaction on to the next slot.
// Depends on pbh_pkg.
module pbh_stage (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [pbh_pkg::STAGE_W-1:0]  stage_id,
    input  logic [pbh_pkg::LEN_W-1:0]    program_length,
    input  logic                         pipe_in_valid,
    input  pbh_pkg::pipe_t               pipe_in,
    output logic                         pipe_out_valid,
    output pbh_pkg::pipe_t               pipe_out
);
    import pbh_pkg::*;

    op_t   op_reg;
    logic  valid_reg;
    pipe_t data_reg;
    pipe_t data_next;
    logic  load_hit;
    logic  run_op;

    // A load writes this slot as it passes, so earlier hashes ahead of it keep the old program.
    always_comb
    begin
        load_hit  = pipe_in_valid && (pipe_in.action == ACT_LOAD)
                    && (CMP_W'(pipe_in.slot) == CMP_W'(stage_id));
        run_op    = pipe_in_valid && (pipe_in.action == ACT_HASH)
                    && (CMP_W'(program_length) > CMP_W'(stage_id));
        data_next = pipe_in;
        if (run_op)
            data_next.regs = exec_op(pipe_in.regs, op_reg);
    end

    always_ff @(posedge clk)
    begin
        if (load_hit)
            op_reg <= pipe_in.op;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= pipe_in_valid;
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign pipe_out_valid = valid_reg;
    assign pipe_out       = data_reg;

endmodule

// File: rtl/programmable_bit_op_hash.sv
// Top level of the programmable bit-operation hash: input packing, the chain of
// slot stages, the program length register and the result register.
// Depends on pbh_pkg and pbh_stage.

// One transaction is taken in every cycle and busy never rises, since the
// receiver cannot stall. Each program slot owns one pipeline stage, and a hash
// gives its result on done after all MAX_OPS slot stages and the result register,
// whatever the program length; loads travel the same pipeline, update their slot
// as they pass it and give no result. Transactions take effect in the order they
// were accepted. The user must write program_length through cfg_valid/cfg_data
// only while no hash is in flight; the block itself does not enforce this.
module programmable_bit_op_hash (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [pbh_pkg::ACTION_W-1:0]   action,
    input  logic [pbh_pkg::SLOT_W-1:0]     slot,
    input  logic [pbh_pkg::KIND_W-1:0]     op_kind,
    input  logic [pbh_pkg::REG_SEL_W-1:0]  first_source,
    input  logic [pbh_pkg::REG_SEL_W-1:0]  second_source,
    input  logic [pbh_pkg::REG_SEL_W-1:0]  destination,
    input  logic [pbh_pkg::FIELD_W-1:0]    mask_value,
    input  logic signed [pbh_pkg::SHAMT_W-1:0] shift_amount,
    input  logic [pbh_pkg::FIELD_W-1:0]    key,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [pbh_pkg::LEN_W-1:0]      cfg_data,
    output logic                           done,
    output logic [pbh_pkg::HASH_W-1:0]     hash_value
);
    import pbh_pkg::*;

    logic               cfg_write;
    logic [LEN_W-1:0]   program_length_reg;
    logic               done_reg;
    logic [HASH_W-1:0]  hash_reg;
    logic               stage_valid [MAX_OPS+1];
    pipe_t              stage_data  [MAX_OPS+1];
    pipe_t              entry;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        entry.action     = action;
        entry.slot       = slot;
        entry.op.kind    = op_kind;
        entry.op.src1    = first_source;
        entry.op.src2    = second_source;
        entry.op.dst     = destination;
        entry.op.mask    = KEY_WIDTH'(mask_value);
        entry.op.shamt   = shift_amount;
        entry.regs       = '0;
        entry.regs[0]    = KEY_WIDTH'(key);
    end

    assign stage_valid[0] = start && !busy;
    assign stage_data[0]  = entry;

    assign cfg_write = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            program_length_reg <= '0;
        else if (cfg_write)
            program_length_reg <= cfg_data;
    end

    for (genvar g = 0; g < MAX_OPS; g++)
    begin : g_stage
        pbh_stage u_stage (
            .clk            (clk),
            .rst_n          (rst_n),
            .stage_id       (STAGE_W'(g)),
            .program_length (program_length_reg),
            .pipe_in_valid  (stage_valid[g]),
            .pipe_in        (stage_data[g]),
            .pipe_out_valid (stage_valid[g+1]),
            .pipe_out       (stage_data[g+1])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= stage_valid[MAX_OPS] && (stage_data[MAX_OPS].action == ACT_HASH);
    end

    always_ff @(posedge clk)
    begin
        hash_reg <= HASH_W'(stage_data[MAX_OPS].regs[0]);
    end

    assign done       = done_reg;
    assign hash_value = hash_reg;

endmodule

// File: rtl/pbh_checker.sv
// Port-level checker for the programmable bit-operation hash and its bind to
// the top level. Depends on pbh_pkg.
module pbh_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          start,
    input logic                          busy,
    input logic [pbh_pkg::ACTION_W-1:0]  action,
    input logic                          done
);
    import pbh_pkg::*;

    // Every accepted hash transaction gives exactly one result after the fixed latency.
    a_hash_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (action == ACT_HASH)) |-> ##PIPE_LATENCY done)
        else $error("hash transaction gave no result");

    a_no_load_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (action == ACT_LOAD)) |-> ##PIPE_LATENCY !done)
        else $error("load transaction gave a result");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy && (action == ACT_HASH), PIPE_LATENCY))
        else $error("result without a matching hash transaction");

endmodule

bind programmable_bit_op_hash pbh_checker u_pbh_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .action (action),
    .done   (done)
);

// File: test/programmable_bit_op_hash_tb.sv
`timescale 1ns / 100ps
// Testbench for programmable_bit_op_hash: a queue-fed driver, a result monitor and a
// predictor that runs the loaded program on each key and checks every hash_value.
// Depends on pbh_pkg and the programmable_bit_op_hash RTL.
module programmable_bit_op_hash_tb;

    import pbh_pkg::*;

    localparam logic [KIND_W-1:0] KIND_SPARE_A = 3'd5;
    localparam logic [KIND_W-1:0] KIND_SPARE_B = 3'd6;
    localparam logic [KIND_W-1:0] KIND_SPARE_C = 3'd7;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int PHASE_ITEMS  = 250;
    localparam int CALM_FIRST   = 400;
    localparam int CALM_LAST    = 800;

    typedef struct {
        logic [ACTION_W-1:0]  act;
        logic [SLOT_W-1:0]    slot;
        logic [KIND_W-1:0]    kind;
        logic [REG_SEL_W-1:0] src1;
        logic [REG_SEL_W-1:0] src2;
        logic [REG_SEL_W-1:0] dst;
        logic [FIELD_W-1:0]   mask;
        logic [SHAMT_W-1:0]   shamt;
        logic [FIELD_W-1:0]   key;
    } request_t;

    logic                  clk;
    logic                  rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    logic [ACTION_W-1:0]   action = ACT_LOAD;
    logic [SLOT_W-1:0]     slot = '0;
    logic [KIND_W-1:0]     op_kind = '0;
    logic [REG_SEL_W-1:0]  first_source = '0;
    logic [REG_SEL_W-1:0]  second_source = '0;
    logic [REG_SEL_W-1:0]  destination = '0;
    logic [FIELD_W-1:0]    mask_value = '0;
    logic signed [SHAMT_W-1:0] shift_amount = '0;
    logic [FIELD_W-1:0]    key = '0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [LEN_W-1:0]      cfg_data = '0;
    logic                  done;
    logic [HASH_W-1:0]     hash_value;

    request_t              pending[$];
    request_t              in_flight;
    logic [HASH_W-1:0]     hashes_due[$];
    op_t                   program_copy[MAX_OPS];
    logic [LEN_W-1:0]      length_copy = '0;
    int                    taken = 0;
    int                    loads_sent = 0;
    int                    hashes_sent = 0;
    int                    mismatches = 0;
    int                    cycles = 0;

    programmable_bit_op_hash DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .action       (action),
        .slot         (slot),
        .op_kind      (op_kind),
        .first_source (first_source),
        .second_source(second_source),
        .destination  (destination),
        .mask_value   (mask_value),
        .shift_amount (shift_amount),
        .key          (key),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .done         (done),
        .hash_value   (hash_value)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic key_t apply_op(input key_t regs[REG_SPACE], input op_t op,
                                      input int which);
        key_t                  a;
        key_t                  b;
        logic [2*KEY_WIDTH-1:0] twice;
        int                    s;
        int                    amount;
        a = (int'(op.src1) < NUM_REGS) ? regs[op.src1] : '0;
        b = (int'(op.src2) < NUM_REGS) ? regs[op.src2] : '0;
        s = int'($signed(op.shamt));
        case (op.kind)
            OP_MASK:   return a & op.mask;
            OP_OR:     return a | b;
            OP_XOR:    return a ^ b;
            OP_SHIFT:
            begin
                if (s >= 0)
                    return (s >= KEY_WIDTH) ? '0 : a >> s;
                return (-s >= KEY_WIDTH) ? '0 : key_t'(a << (-s));
            end
            OP_ROTATE:
            begin
                amount = (s >= 0) ? s % KEY_WIDTH : (KEY_WIDTH - (-s) % KEY_WIDTH) % KEY_WIDTH;
                twice = {a, a} >> amount;
                return twice[KEY_WIDTH-1:0];
            end
            default:   return regs[which];
        endcase
    endfunction

    function automatic logic [HASH_W-1:0] hash_of(input logic [FIELD_W-1:0] k);
        key_t regs[REG_SPACE];
        op_t  op;
        int   steps;
        for (int r = 0; r < REG_SPACE; r++)
            regs[r] = '0;
        regs[0] = key_t'(k);
        steps = (int'(length_copy) > MAX_OPS) ? MAX_OPS : int'(length_copy);
        for (int i = 0; i < steps; i++)
        begin
            op = program_copy[i];
            if (int'(op.dst) < NUM_REGS)
                regs[op.dst] = apply_op(regs, op, int'(op.dst));
        end
        return HASH_W'(regs[0]);
    endfunction

    function automatic request_t load_req(input int s, input logic [KIND_W-1:0] kind,
                                          input int s1, input int s2, input int d,
                                          input int mask, input int shamt);
        request_t r;
        r.act   = ACT_LOAD;
        r.slot  = SLOT_W'(s);
        r.kind  = kind;
        r.src1  = REG_SEL_W'(s1);
        r.src2  = REG_SEL_W'(s2);
        r.dst   = REG_SEL_W'(d);
        r.mask  = FIELD_W'(mask);
        r.shamt = SHAMT_W'(shamt);
        r.key   = FIELD_W'($urandom);
        return r;
    endfunction

    function automatic request_t hash_req(input int k);
        request_t r;
        r = load_req($urandom, KIND_W'($urandom), $urandom, $urandom, $urandom,
                     $urandom, $urandom);
        r.act = ACT_HASH;
        r.key = FIELD_W'(k);
        return r;
    endfunction

    function automatic request_t random_req();
        int pick;
        int k;
        pick = $urandom_range(99);
        if (pick < 30)
            return load_req($urandom, KIND_W'($urandom), $urandom, $urandom, $urandom,
                            $urandom, $urandom);
        k = $urandom;
        if (pick < 34)
            k = 0;
        else if (pick < 38)
            k = (1 << FIELD_W) - 1;
        return hash_req(k);
    endfunction

    task automatic add_pending(input request_t r);
        pending = {pending, r};
    endtask

    task automatic absorb(input request_t r);
        op_t op;
        if (r.act == ACT_HASH)
        begin
            hashes_due = {hashes_due, hash_of(r.key)};
            hashes_sent++;
        end
        else
        begin
            op.kind  = r.kind;
            op.src1  = r.src1;
            op.src2  = r.src2;
            op.dst   = r.dst;
            op.mask  = key_t'(r.mask);
            op.shamt = r.shamt;
            if (int'(r.slot) < MAX_OPS)
                program_copy[r.slot] = op;
            loads_sent++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else
        begin
            if (start && !busy)
            begin
                absorb(in_flight);
                taken++;
            end
            if (!start || !busy)
            begin
                if (pending.size() != 0 &&
                    ((taken >= CALM_FIRST && taken < CALM_LAST) || $urandom_range(99) >= 23))
                begin
                    in_flight = pending.pop_front();
                    action        <= in_flight.act;
                    slot          <= in_flight.slot;
                    op_kind       <= in_flight.kind;
                    first_source  <= in_flight.src1;
                    second_source <= in_flight.src2;
                    destination   <= in_flight.dst;
                    mask_value    <= in_flight.mask;
                    shift_amount  <= in_flight.shamt;
                    key           <= in_flight.key;
                    start         <= 1'b1;
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk)
    begin : check_result
        logic [HASH_W-1:0] want;
        if (rst_n && done)
        begin
            if (hashes_due.size() == 0)
            begin
                $error("hash_value: expected none, actual %0h", hash_value);
                mismatches++;
            end
            else
            begin
                want = hashes_due.pop_front();
                if (hash_value !== want)
                begin
                    $error("hash_value: expected %0h, actual %0h", want, hash_value);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic drain();
        @(posedge clk);
        while (pending.size() != 0 || start || hashes_due.size() != 0)
            @(posedge clk);
        repeat (PIPE_LATENCY + 4) @(posedge clk);
    endtask

    task automatic write_length(input int value);
        @(posedge clk);
        cfg_data  <= LEN_W'(value);
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        length_copy = LEN_W'(value);
    endtask

    initial
    begin : stimulus
        int lengths[6];
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // With the reset program length of zero the key comes straight back.
        add_pending(hash_req(0));
        add_pending(hash_req((1 << FIELD_W) - 1));
        add_pending(load_req(0, OP_MASK, 0, 0, 1, 1023, 0));
        add_pending(load_req(1, OP_ROTATE, 0, 0, 2, 0, -16));
        add_pending(load_req(2, OP_XOR, 1, 2, 3, 0, 0));
        add_pending(load_req(3, OP_SHIFT, 3, 0, 1, 0, -10));
        add_pending(load_req(4, OP_SHIFT, 0, 0, 2, 0, 15));
        add_pending(load_req(5, OP_OR, 3, 0, 0, 0, 0));
        add_pending(load_req(6, OP_ROTATE, 0, 0, 1, 0, 15));
        add_pending(load_req(7, OP_SHIFT, 1, 0, 2, 0, -3));
        add_pending(load_req(8, KIND_SPARE_A, 1, 2, 0, 1023, 5));
        add_pending(load_req(9, KIND_SPARE_B, 2, 3, 0, 0, -5));
        add_pending(load_req(10, KIND_SPARE_C, 3, 1, 0, 1023, 10));
        add_pending(load_req(11, OP_XOR, 2, 1, 0, 0, 0));
        add_pending(load_req(12, OP_MASK, 0, 0, 3, 0, 0));
        add_pending(load_req(13, OP_SHIFT, 0, 0, 2, 0, 1));
        add_pending(load_req(14, OP_ROTATE, 0, 0, 1, 0, -1));
        add_pending(load_req(15, OP_OR, 1, 2, 0, 0, 0));
        drain();

        write_length(MAX_OPS);
        add_pending(hash_req((1 << FIELD_W) - 1));
        add_pending(hash_req('h2AA));
        add_pending(hash_req('h155));
        add_pending(hash_req(1));
        drain();

        lengths[0] = MAX_OPS;
        lengths[1] = (1 << LEN_W) - 1;
        lengths[2] = 1;
        lengths[3] = 0;
        lengths[4] = $urandom_range(MAX_OPS - 1, 2);
        lengths[5] = $urandom_range((1 << LEN_W) - 2, MAX_OPS + 1);
        foreach (lengths[p])
        begin
            write_length(lengths[p]);
            repeat (PHASE_ITEMS) add_pending(random_req());
            drain();
        end

        $display("Ran %0d program loads and %0d hashed keys over program lengths 0 to %0d,",
                 loads_sent, hashes_sent, (1 << LEN_W) - 1);
        $display("with random start gaps and a full drain before each length change.");
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

// File: files.f
rtl/pbh_pkg.sv
rtl/pbh_stage.sv
rtl/programmable_bit_op_hash.sv
rtl/pbh_checker.sv
test/programmable_bit_op_hash_tb.sv
